FILE: hw/rtl/dbhg_pkg.sv
package dbhg_pkg;

    // Field tags double as parser phases
    typedef enum logic [3:0] {
        PH_PROTO    = 4'd0,
        PH_VERSION  = 4'd1,
        PH_THREAD   = 4'd2,
        PH_AUTH1    = 4'd3,
        PH_FILLER   = 4'd4,
        PH_CAPS_LO  = 4'd5,
        PH_CHARSET  = 4'd6,
        PH_STATUS   = 4'd7,
        PH_CAPS_HI  = 4'd8,
        PH_AUTH_LEN = 4'd9,
        PH_RESERVED = 4'd10,
        PH_AUTH2    = 4'd11,
        PH_PAD      = 4'd12,
        PH_NAME     = 4'd13,
        PH_DONE     = 4'd14
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_OK   = 2'd1,
        ST_FAIL = 2'd2
    } t_outcome;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_PLUGIN_MASK = 2'd0;
    localparam logic [1:0] CFG_SECURE_MASK = 2'd1;
    localparam logic [1:0] CFG_OLD_PROTO   = 2'd2;

    localparam logic [31:0] PLUGIN_MASK_RST = 32'h0008_0000;
    localparam logic [31:0] SECURE_MASK_RST = 32'h0000_8000;
    localparam logic [7:0]  OLD_PROTO_RST   = 8'd9;

    localparam logic [7:0] THREAD_LEN   = 8'd4;
    localparam logic [7:0] PART1_LEN    = 8'd8;
    localparam logic [7:0] RESERVED_LEN = 8'd10;
    localparam logic [7:0] SECURE_LEN   = 8'd12;
    localparam logic [7:0] PLUGIN_PAD   = 8'd13;
    localparam logic [7:0] CNT_MAX      = 8'd255;

    typedef struct packed {
        logic [31:0] plugin_mask;
        logic [31:0] secure_mask;
        logic [7:0]  old_proto;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  count;
        logic [7:0]  part2_left;
        logic [3:0]  pad_left;
        logic [7:0]  proto;
        logic [31:0] thread;
        logic [31:0] caps;
        logic [7:0]  charset;
        logic [15:0] status;
        logic [7:0]  auth_len;
        t_outcome    outcome;
    } t_state;

    localparam t_state STATE_RST = '{
        phase:      PH_PROTO,
        count:      8'd0,
        part2_left: 8'd0,
        pad_left:   4'd0,
        proto:      8'd0,
        thread:     32'd0,
        caps:       32'd0,
        charset:    8'd0,
        status:     16'd0,
        auth_len:   8'd0,
        outcome:    ST_BUSY
    };

    typedef struct packed {
        logic [3:0]  field_tag;
        logic [7:0]  field_byte_index;
        logic [7:0]  echo_byte;
        logic [1:0]  parse_status;
        logic        message_end;
        logic [7:0]  protocol;
        logic [31:0] thread_word;
        logic [31:0] capabilities;
        logic [7:0]  charset;
        logic [15:0] srv_status;
        logic [7:0]  auth_length;
    } t_result;

endpackage

FILE: hw/rtl/dbhg_step.sv
module dbhg_step
    import dbhg_pkg::*;
(
    input  t_state     i_state,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_last,
    output t_state     o_next_state,
    output t_result    o_result
);

    t_phase     nx_phase;
    logic       fin;
    t_outcome   fin_code;
    logic       plugin;
    logic       secure;
    logic [7:0] len2;
    logic [3:0] pad_init;
    logic [7:0] part2_dec;
    logic [3:0] pad_dec;
    t_state     post;

    assign plugin    = |(i_state.caps & i_cfg.plugin_mask);
    assign secure    = |(i_state.caps & i_cfg.secure_mask);
    assign len2      = (i_state.auth_len > PART1_LEN) ? (i_state.auth_len - PART1_LEN) : 8'd0;
    assign pad_init  = (len2 < PLUGIN_PAD) ? 4'(PLUGIN_PAD - len2) : 4'd0;
    assign part2_dec = (i_state.part2_left != 8'd0) ? (i_state.part2_left - 8'd1) : 8'd0;
    assign pad_dec   = (i_state.pad_left != 4'd0) ? (i_state.pad_left - 4'd1) : 4'd0;

    // next phase
    always_comb begin
        nx_phase = i_state.phase;
        fin      = 1'b0;
        fin_code = ST_OK;
        case (i_state.phase)
            PH_PROTO:    nx_phase = PH_VERSION;
            PH_VERSION:  if (i_data_byte == 8'd0) nx_phase = PH_THREAD;
            PH_THREAD:   if (i_state.count >= THREAD_LEN - 8'd1) nx_phase = PH_AUTH1;
            PH_AUTH1:    if (i_state.count >= PART1_LEN - 8'd1) nx_phase = PH_FILLER;
            PH_FILLER: begin
                if (i_state.proto == i_cfg.old_proto) fin = 1'b1;
                else nx_phase = PH_CAPS_LO;
            end
            PH_CAPS_LO:  if (i_state.count >= 8'd1) nx_phase = PH_CHARSET;
            PH_CHARSET:  nx_phase = PH_STATUS;
            PH_STATUS:   if (i_state.count >= 8'd1) nx_phase = PH_CAPS_HI;
            PH_CAPS_HI:  if (i_state.count >= 8'd1) nx_phase = PH_AUTH_LEN;
            PH_AUTH_LEN: nx_phase = PH_RESERVED;
            PH_RESERVED: begin
                if (i_state.count >= RESERVED_LEN - 8'd1) begin
                    if (plugin) begin
                        if (len2 != 8'd0)          nx_phase = PH_AUTH2;
                        else if (pad_init != 4'd0) nx_phase = PH_PAD;
                        else                       nx_phase = PH_NAME;
                    end else if (secure) begin
                        nx_phase = PH_AUTH2;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            PH_AUTH2: begin
                if (part2_dec == 8'd0) begin
                    if (i_state.pad_left != 4'd0) nx_phase = PH_PAD;
                    else if (plugin)              nx_phase = PH_NAME;
                    else                          fin = 1'b1;
                end
            end
            PH_PAD: begin
                if (pad_dec == 4'd0) begin
                    if (plugin) nx_phase = PH_NAME;
                    else        fin = 1'b1;
                end
            end
            PH_NAME: begin
                if (i_data_byte == 8'd0) begin
                    fin      = 1'b1;
                    fin_code = (i_state.auth_len < PART1_LEN) ? ST_FAIL : ST_OK;
                end
            end
            default: nx_phase = PH_DONE;
        endcase
        if (fin) nx_phase = PH_DONE;
    end

    // field registers, counters and result
    always_comb begin
        post       = i_state;
        post.phase = nx_phase;
        case (i_state.phase)
            PH_PROTO: post.proto = i_data_byte;
            PH_THREAD: begin
                case (i_state.count[1:0])
                    2'd0:    post.thread[7:0]   = i_data_byte;
                    2'd1:    post.thread[15:8]  = i_data_byte;
                    2'd2:    post.thread[23:16] = i_data_byte;
                    default: post.thread[31:24] = i_data_byte;
                endcase
            end
            PH_CAPS_LO: begin
                if (i_state.count[0]) post.caps[15:8] = i_data_byte;
                else                  post.caps[7:0]  = i_data_byte;
            end
            PH_CHARSET: post.charset = i_data_byte;
            PH_STATUS: begin
                if (i_state.count[0]) post.status[15:8] = i_data_byte;
                else                  post.status[7:0]  = i_data_byte;
            end
            PH_CAPS_HI: begin
                if (i_state.count[0]) post.caps[31:24] = i_data_byte;
                else                  post.caps[23:16] = i_data_byte;
            end
            PH_AUTH_LEN: post.auth_len = i_data_byte;
            PH_RESERVED: begin
                if (i_state.count >= RESERVED_LEN - 8'd1) begin
                    if (plugin) begin
                        post.part2_left = len2;
                        post.pad_left   = pad_init;
                    end else if (secure) begin
                        post.part2_left = SECURE_LEN;
                        post.pad_left   = 4'd1;
                    end
                end
            end
            PH_AUTH2: post.part2_left = part2_dec;
            PH_PAD:   post.pad_left   = pad_dec;
            default:  post.phase      = nx_phase;
        endcase

        if (fin) post.outcome = fin_code;

        // a finish keeps counting from where the field stood
        if ((nx_phase != i_state.phase) && !fin) post.count = 8'd0;
        else if (i_state.count != CNT_MAX)       post.count = i_state.count + 8'd1;

        if (i_is_last && (post.phase != PH_DONE)) begin
            post.phase = PH_DONE;
            // cut right after caps low is a valid short greeting
            if ((nx_phase == PH_CHARSET) && (post.count == 8'd0)) post.outcome = ST_OK;
            else                                                  post.outcome = ST_FAIL;
        end

        o_result.field_tag        = (i_state.phase > PH_DONE) ? PH_DONE : i_state.phase;
        o_result.field_byte_index = i_state.count;
        o_result.echo_byte        = i_data_byte;
        o_result.parse_status     = post.outcome;
        o_result.message_end      = i_is_last;
        o_result.protocol         = post.proto;
        o_result.thread_word      = post.thread;
        o_result.capabilities     = post.caps;
        o_result.charset          = post.charset;
        o_result.srv_status       = post.status;
        o_result.auth_length      = post.auth_len;

        o_next_state = i_is_last ? STATE_RST : post;
    end

endmodule

FILE: hw/rtl/db_handshake_greeting_parser.sv
// Each accepted byte's result lands in the output register. Throughput is
// one byte per cycle unless the receiver stalls; the field state advances in
// the same cycle the byte is taken; the output frees as its result is taken.
// Reset (synchronous, active low): parser back at the protocol field, all
// gathered fields zero, config registers at defaults, no result pending.
module db_handshake_greeting_parser
    import dbhg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    // result stream
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_field_tag,
    output logic [7:0]  o_field_byte_index,
    output logic [7:0]  o_echo_byte,
    output logic [1:0]  o_parse_status,
    output logic        o_message_end,
    output logic [7:0]  o_protocol_out,
    output logic [31:0] o_thread_word_out,
    output logic [31:0] o_capabilities_out,
    output logic [7:0]  o_charset_out,
    output logic [15:0] o_srv_status_out,
    output logic [7:0]  o_auth_length_out,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    in_acc;

    // Output register: a new byte is taken whenever the slot is empty or
    // its result leaves in the same cycle.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Config registers; an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plugin_mask <= PLUGIN_MASK_RST;
            r_cfg.secure_mask <= SECURE_MASK_RST;
            r_cfg.old_proto   <= OLD_PROTO_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PLUGIN_MASK: r_cfg.plugin_mask <= i_cfg_data;
                CFG_SECURE_MASK: r_cfg.secure_mask <= i_cfg_data;
                CFG_OLD_PROTO:   r_cfg.old_proto   <= i_cfg_data[7:0];
                default:         r_cfg.old_proto   <= r_cfg.old_proto;
            endcase
        end
    end

    // Per-byte field logic: tags the byte, updates gathered fields,
    // and re-arms on the last byte of a message.
    dbhg_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_data_byte  (i_data_byte),
        .i_is_last    (i_is_last),
        .o_next_state (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_field_tag         = r_result.field_tag;
    assign o_field_byte_index  = r_result.field_byte_index;
    assign o_echo_byte         = r_result.echo_byte;
    assign o_parse_status      = r_result.parse_status;
    assign o_message_end       = r_result.message_end;
    assign o_protocol_out      = r_result.protocol;
    assign o_thread_word_out   = r_result.thread_word;
    assign o_capabilities_out  = r_result.capabilities;
    assign o_charset_out       = r_result.charset;
    assign o_srv_status_out    = r_result.srv_status;
    assign o_auth_length_out   = r_result.auth_length;

    // last byte of a message always re-arms the parser
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_is_last) |=> (r_state.phase == PH_PROTO) && (r_state.outcome == ST_BUSY))
        else $error("parser not re-armed after last byte");

    // a completed parse always carries a verdict
    a_done_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DONE) |-> (r_state.outcome != ST_BUSY))
        else $error("done phase without outcome");

    // a verdict only exists once the parse is complete
    a_verdict_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.outcome != ST_BUSY) |-> (r_state.phase == PH_DONE))
        else $error("outcome set while still parsing");

    // bytes after completion are tagged as trailing
    a_trailing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_state.phase == PH_DONE)) |=> (o_field_tag == PH_DONE))
        else $error("trailing byte mis-tagged");

    // every accepted byte yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted byte produced no result");

endmodule

FILE: verif/db_handshake_greeting_parser_tb.sv
module db_handshake_greeting_parser_tb;
    import dbhg_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off, fills the block
    localparam int BYTES_PER_PHASE = 25;    // random bytes offered per config phase
    localparam int NUM_PHASES      = 6;
    localparam int MAX_REPORTS     = 10;

    // greeting shapes the stimulus generator aims for
    typedef enum int {
        LAY_OLD,     // old protocol, stops after the filler
        LAY_EARLY,   // clean end on the second caps-low byte
        LAY_PLUGIN,  // plugin auth data, pad, zero-terminated name
        LAY_SECURE,  // twelve secure bytes and a pad
        LAY_NONE     // ends on the last reserved byte
    } t_layout;

    // one pending input transaction
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_xact;

    // ---------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ---------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_is_last   = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_field_tag;
    logic [7:0]  o_field_byte_index;
    logic [7:0]  o_echo_byte;
    logic [1:0]  o_parse_status;
    logic        o_message_end;
    logic [7:0]  o_protocol_out;
    logic [31:0] o_thread_word_out;
    logic [31:0] o_capabilities_out;
    logic [7:0]  o_charset_out;
    logic [15:0] o_srv_status_out;
    logic [7:0]  o_auth_length_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [31:0] i_cfg_data  = 32'd0;

    db_handshake_greeting_parser dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_data_byte         (i_data_byte),
        .i_is_last           (i_is_last),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_field_tag         (o_field_tag),
        .o_field_byte_index  (o_field_byte_index),
        .o_echo_byte         (o_echo_byte),
        .o_parse_status      (o_parse_status),
        .o_message_end       (o_message_end),
        .o_protocol_out      (o_protocol_out),
        .o_thread_word_out   (o_thread_word_out),
        .o_capabilities_out  (o_capabilities_out),
        .o_charset_out       (o_charset_out),
        .o_srv_status_out    (o_srv_status_out),
        .o_auth_length_out   (o_auth_length_out),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // Testbench state
    // ---------------------------------------------------------------
    t_byte_xact  greeting_bytes[$];    // bytes waiting for the driver
    t_result     predicted_fields[$];  // expected results, oldest first
    logic [7:0]  greet_buf[$];         // scratch for one generated greeting

    int          tx_idle     = 0;      // sender idle percentage
    int          rx_idle     = 0;      // receiver idle percentage
    bit          rx_hold_go  = 1'b0;
    bit          rx_hold     = 1'b0;
    bit          in_taken    = 1'b0;   // driver's item went through at last rising edge
    int          phase_bytes = 0;
    int          cycle_cnt   = 0;
    int          err_cnt     = 0;
    t_result     seen_result;
    t_result     want_result;

    // shadow config, follows every accepted register write
    logic [31:0] cfg_plugin;
    logic [31:0] cfg_secure;
    logic [7:0]  cfg_old;

    // shadow parser state
    t_phase      gp_phase;
    logic [7:0]  gp_count;
    logic [7:0]  gp_part2;
    logic [3:0]  gp_pad;
    logic [7:0]  gp_proto;
    logic [31:0] gp_thread;
    logic [31:0] gp_caps;
    logic [7:0]  gp_charset;
    logic [15:0] gp_status;
    logic [7:0]  gp_auth_len;
    t_outcome    gp_outcome;

    // clock, period 10
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Greeting predictor
    // ---------------------------------------------------------------
    function automatic void rearm_parser();
        gp_phase    = PH_PROTO;
        gp_count    = 8'd0;
        gp_part2    = 8'd0;
        gp_pad      = 4'd0;
        gp_proto    = 8'd0;
        gp_thread   = 32'd0;
        gp_caps     = 32'd0;
        gp_charset  = 8'd0;
        gp_status   = 16'd0;
        gp_auth_len = 8'd0;
        gp_outcome  = ST_BUSY;
    endfunction

    function automatic void close_parse(input t_outcome res);
        gp_phase   = PH_DONE;
        gp_outcome = res;
    endfunction

    // Tags one byte, advances the shadow parser and returns the expected result.
    // Note: a completed parse parks the phase at done directly, so the field
    // counter keeps counting instead of restarting at zero.
    function automatic t_result tag_next_byte(input logic [7:0] b, input logic last);
        t_result    r;
        t_phase     tag;
        t_phase     nxt;
        logic [7:0] idx;
        logic [7:0] len2;
        bit         plugin;
        tag    = gp_phase;
        idx    = gp_count;
        nxt    = gp_phase;
        plugin = (gp_caps & cfg_plugin) != 32'd0;
        case (gp_phase)
            PH_PROTO: begin
                gp_proto = b;
                nxt      = PH_VERSION;
            end
            PH_VERSION: if (b == 8'd0) nxt = PH_THREAD;
            PH_THREAD: begin
                gp_thread[8*gp_count[1:0] +: 8] = b;
                if (gp_count >= 8'd3) nxt = PH_AUTH1;
            end
            PH_AUTH1: if (gp_count >= PART1_LEN - 8'd1) nxt = PH_FILLER;
            PH_FILLER: begin
                if (gp_proto == cfg_old) begin
                    close_parse(ST_OK);
                    nxt = PH_DONE;
                end else begin
                    nxt = PH_CAPS_LO;
                end
            end
            PH_CAPS_LO: begin
                gp_caps[8*gp_count[0] +: 8] = b;
                if (gp_count >= 8'd1) nxt = PH_CHARSET;
            end
            PH_CHARSET: begin
                gp_charset = b;
                nxt        = PH_STATUS;
            end
            PH_STATUS: begin
                gp_status[8*gp_count[0] +: 8] = b;
                if (gp_count >= 8'd1) nxt = PH_CAPS_HI;
            end
            PH_CAPS_HI: begin
                gp_caps[16 + 8*gp_count[0] +: 8] = b;
                if (gp_count >= 8'd1) nxt = PH_AUTH_LEN;
            end
            PH_AUTH_LEN: begin
                gp_auth_len = b;
                nxt         = PH_RESERVED;
            end
            PH_RESERVED: begin
                if (gp_count >= RESERVED_LEN - 8'd1) begin
                    // layout picked from the merged caps; plugin wins
                    if ((gp_caps & cfg_plugin) != 32'd0) begin
                        len2     = (gp_auth_len > PART1_LEN) ? gp_auth_len - PART1_LEN : 8'd0;
                        gp_part2 = len2;
                        gp_pad   = 4'(PLUGIN_PAD - ((len2 < PLUGIN_PAD) ? len2 : PLUGIN_PAD));
                        if (len2 != 8'd0) nxt = PH_AUTH2;
                        else if (gp_pad != 4'd0) nxt = PH_PAD;
                        else nxt = PH_NAME;
                    end else if ((gp_caps & cfg_secure) != 32'd0) begin
                        gp_part2 = SECURE_LEN;
                        gp_pad   = 4'd1;
                        nxt      = PH_AUTH2;
                    end else begin
                        close_parse(ST_OK);
                        nxt = PH_DONE;
                    end
                end
            end
            PH_AUTH2: begin
                if (gp_part2 != 8'd0) gp_part2 = gp_part2 - 8'd1;
                if (gp_part2 == 8'd0) begin
                    if (gp_pad != 4'd0) nxt = PH_PAD;
                    else if (plugin) nxt = PH_NAME;
                    else begin
                        close_parse(ST_OK);
                        nxt = PH_DONE;
                    end
                end
            end
            PH_PAD: begin
                if (gp_pad != 4'd0) gp_pad = gp_pad - 4'd1;
                if (gp_pad == 4'd0) begin
                    if (plugin) nxt = PH_NAME;
                    else begin
                        close_parse(ST_OK);
                        nxt = PH_DONE;
                    end
                end
            end
            PH_NAME: begin
                if (b == 8'd0) begin
                    // length check on the declared auth length
                    close_parse((gp_auth_len < PART1_LEN) ? ST_FAIL : ST_OK);
                    nxt = PH_DONE;
                end
            end
            default: begin
                tag = PH_DONE;
                nxt = PH_DONE;
            end
        endcase

        if (nxt != gp_phase) begin
            gp_phase = nxt;
            gp_count = 8'd0;
        end else if (gp_count < CNT_MAX) begin
            gp_count = gp_count + 8'd1;
        end

        if (last && gp_phase != PH_DONE) begin
            // last byte on the second caps-low byte is a clean end
            if (gp_phase == PH_CHARSET && gp_count == 8'd0) close_parse(ST_OK);
            else close_parse(ST_FAIL);
        end

        r.field_tag        = tag;
        r.field_byte_index = idx;
        r.echo_byte        = b;
        r.parse_status     = gp_outcome;
        r.message_end      = last;
        r.protocol         = gp_proto;
        r.thread_word      = gp_thread;
        r.capabilities     = gp_caps;
        r.charset          = gp_charset;
        r.srv_status       = gp_status;
        r.auth_length      = gp_auth_len;
        if (last) rearm_parser();
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [7:0] nonzero_byte();
        return 8'($urandom_range(255, 1));
    endfunction

    // Builds one greeting into greet_buf, steering the caps toward a layout
    // under the current shadow config.
    function automatic void build_greeting(input t_layout lay, input int ver_len,
                                           input logic [7:0] alen, input int name_len,
                                           input int extra);
        logic [31:0] caps;
        logic [31:0] sec_only;
        logic [7:0]  proto;
        logic [7:0]  len2;
        int          npad;
        greet_buf.delete();
        proto = 8'($urandom);
        if (lay == LAY_OLD) proto = cfg_old;
        else if (proto == cfg_old) proto = proto + 8'd1;
        greet_buf.push_back(proto);
        repeat (ver_len) greet_buf.push_back(nonzero_byte());
        greet_buf.push_back(8'd0);
        repeat (13) greet_buf.push_back(8'($urandom));   // thread id, auth part 1, filler
        if (lay != LAY_OLD) begin
            caps = $urandom;
            case (lay)
                LAY_PLUGIN: begin
                    if ((caps & cfg_plugin) == 32'd0) caps |= cfg_plugin & (~cfg_plugin + 32'd1);
                end
                LAY_SECURE: begin
                    caps     &= ~cfg_plugin;
                    sec_only  = cfg_secure & ~cfg_plugin;
                    if ((caps & sec_only) == 32'd0) caps |= sec_only & (~sec_only + 32'd1);
                end
                default: caps &= ~(cfg_plugin | cfg_secure);
            endcase
            greet_buf.push_back(caps[7:0]);
            greet_buf.push_back(caps[15:8]);
            if (lay != LAY_EARLY) begin
                repeat (3) greet_buf.push_back(8'($urandom));   // charset, status
                greet_buf.push_back(caps[23:16]);
                greet_buf.push_back(caps[31:24]);
                greet_buf.push_back(alen);
                repeat (10) greet_buf.push_back(8'($urandom));  // reserved
                if ((caps & cfg_plugin) != 32'd0) begin
                    len2 = (alen > PART1_LEN) ? alen - PART1_LEN : 8'd0;
                    npad = (len2 < PLUGIN_PAD) ? PLUGIN_PAD - len2 : 0;
                    repeat (len2) greet_buf.push_back(8'($urandom));
                    repeat (npad) greet_buf.push_back(8'($urandom));
                    repeat (name_len) greet_buf.push_back(nonzero_byte());
                    greet_buf.push_back(8'd0);
                end else if ((caps & cfg_secure) != 32'd0) begin
                    repeat (13) greet_buf.push_back(8'($urandom));
                end
            end
        end
        repeat (extra) greet_buf.push_back(8'($urandom));
    endfunction

    // Hands greet_buf[from..upto-1] to the driver, last mark on the final byte.
    task automatic queue_greeting_bytes(input int from, input int upto, input bit mark);
        t_byte_xact x;
        for (int i = from; i < upto; i++) begin
            x.data = greet_buf[i];
            x.last = mark && (i == upto - 1);
            greeting_bytes.push_back(x);
            phase_bytes++;
        end
    endtask

    // Block idle: nothing queued, nothing offered, every result back.
    task automatic drain_parser();
        while (greeting_bytes.size() != 0 || i_in_valid || predicted_fields.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_PLUGIN_MASK: cfg_plugin = data;
            CFG_SECURE_MASK: cfg_secure = data;
            CFG_OLD_PROTO:   cfg_old    = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic show_result(input string label, input t_result r);
        $display({"  %s tag=%0d idx=%0d byte=%02h st=%0d end=%0d proto=%02h",
                  " thr=%08h caps=%08h cs=%02h ss=%04h al=%02h"},
                 label, r.field_tag, r.field_byte_index, r.echo_byte, r.parse_status,
                 r.message_end, r.protocol, r.thread_word, r.capabilities, r.charset,
                 r.srv_status, r.auth_length);
    endtask

    // ---------------------------------------------------------------
    // Driver: offers the front of greeting_bytes, holds it until taken
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (greeting_bytes.size() != 0 && int'($urandom_range(99)) >= tx_idle) begin
                i_in_valid  <= 1'b1;
                i_data_byte <= greeting_bytes[0].data;
                i_is_last   <= greeting_bytes[0].last;
            end else begin
                i_in_valid  <= 1'b0;
            end
        end
    end

    // receiver ready, random idling plus the long hold-off
    always @(negedge i_clk) begin
        i_out_ready <= !rx_hold && (int'($urandom_range(99)) >= rx_idle);
    end

    // long hold-off, counted in its own process
    initial begin
        wait (rx_hold_go);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // ---------------------------------------------------------------
    // Monitor: predicts on each input transaction, checks each result
    // transaction against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predicted_fields.push_back(tag_next_byte(i_data_byte, i_is_last));
                void'(greeting_bytes.pop_front());
                in_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                seen_result = {o_field_tag, o_field_byte_index, o_echo_byte, o_parse_status,
                               o_message_end, o_protocol_out, o_thread_word_out,
                               o_capabilities_out, o_charset_out, o_srv_status_out,
                               o_auth_length_out};
                if (predicted_fields.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("cycle %0d: result with nothing expected", cycle_cnt);
                        show_result("got", seen_result);
                    end
                end else begin
                    want_result = predicted_fields.pop_front();
                    if (seen_result !== want_result) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("cycle %0d: result mismatch", cycle_cnt);
                            show_result("exp", want_result);
                            show_result("got", seen_result);
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: reset, directed greetings, then random phases with a
    // fresh config each, written only while the block is idle
    // ---------------------------------------------------------------
    initial begin
        int          pick;
        t_layout     lay;
        logic [7:0]  alen;
        logic [31:0] pm;
        logic [31:0] sm;
        logic [7:0]  op;

        cfg_plugin = PLUGIN_MASK_RST;
        cfg_secure = SECURE_MASK_RST;
        cfg_old    = OLD_PROTO_RST;
        rearm_parser();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset config, sender 22 / receiver 57
        tx_idle = 22;
        rx_idle = 57;
        // old protocol, then trailing bytes that only count
        build_greeting(LAY_OLD, 2, 8'd0, 0, 2);
        queue_greeting_bytes(0, greet_buf.size(), 1'b1);
        // clean end right after caps low
        build_greeting(LAY_EARLY, 1, 8'd0, 0, 0);
        queue_greeting_bytes(0, greet_buf.size(), 1'b1);
        // plugin with auth length below 8: fails at the name's zero
        build_greeting(LAY_PLUGIN, 0, 8'd5, 0, 0);
        queue_greeting_bytes(0, greet_buf.size(), 1'b1);
        // truncated in the version string, then on the filler
        build_greeting(LAY_PLUGIN, 6, 8'd20, 1, 0);
        queue_greeting_bytes(0, 5, 1'b1);
        build_greeting(LAY_NONE, 0, 8'd0, 0, 0);
        queue_greeting_bytes(0, 15, 1'b1);
        // one-byte message, then all-ones bytes ending in a zero
        greet_buf = {8'h00};
        queue_greeting_bytes(0, 1, 1'b1);
        greet_buf = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        queue_greeting_bytes(0, 5, 1'b1);
        // config change mid-message: plugin mask dropped inside reserved bytes
        build_greeting(LAY_PLUGIN, 0, 8'd20, 2, 0);
        queue_greeting_bytes(0, 26, 1'b0);
        drain_parser();
        write_reg(CFG_PLUGIN_MASK, 32'd0);
        queue_greeting_bytes(26, greet_buf.size(), 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_parser();
            if (p < 2) begin
                tx_idle = 22;
                rx_idle = 57;
            end else if (p < 4) begin
                tx_idle = 57;
                rx_idle = 22;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            case (p)
                0: begin pm = '1; sm = '0; op = 8'hFF; end
                1: begin pm = '0; sm = '1; op = 8'h00; end
                2: begin pm = PLUGIN_MASK_RST; sm = SECURE_MASK_RST; op = OLD_PROTO_RST; end
                3: begin pm = $urandom; sm = $urandom; op = 8'($urandom); end
                4: begin
                    pm = 32'd1 << $urandom_range(31);
                    sm = 32'd1 << $urandom_range(31);
                    op = 8'($urandom);
                end
                default: begin pm = '0; sm = '0; op = 8'($urandom); end
            endcase
            write_reg(CFG_PLUGIN_MASK, pm);
            write_reg(CFG_SECURE_MASK, sm);
            // upper data bits are don't-care for the protocol code
            write_reg(CFG_OLD_PROTO, {24'($urandom), op});
            if (p == 4) rx_hold_go = 1'b1;

            phase_bytes = 0;
            while (phase_bytes < BYTES_PER_PHASE) begin
                pick = $urandom_range(99);
                lay  = t_layout'($urandom_range(4));
                alen = ($urandom_range(9) == 0) ? 8'($urandom_range(60)) : 8'($urandom_range(20));
                build_greeting(lay, $urandom_range(5), alen, $urandom_range(4),
                               ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0);
                if (pick < 70) begin
                    queue_greeting_bytes(0, greet_buf.size(), 1'b1);
                end else if (pick < 90) begin
                    // broken greeting, cut short anywhere
                    queue_greeting_bytes(0, $urandom_range(greet_buf.size() - 1, 1), 1'b1);
                end else begin
                    // noise
                    greet_buf.delete();
                    repeat ($urandom_range(20, 1)) greet_buf.push_back(8'($urandom));
                    queue_greeting_bytes(0, greet_buf.size(), 1'b1);
                end
            end
        end

        drain_parser();
        repeat (4) @(negedge i_clk);
        if (predicted_fields.size() != 0) begin
            err_cnt += predicted_fields.size();
            $display("results missing: %0d", predicted_fields.size());
        end
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
